// ===== hw/rtl/pip_pkg.sv =====
// Shared constants and types for the even-odd point-in-polygon block.
`timescale 1ns / 1ps

package pip_pkg;

	localparam int PIP_COORD_BITS = 24;

	typedef logic [1:0] tally_t;

	localparam tally_t TALLY_EMPTY = 2'd0;
	localparam tally_t TALLY_PAIR  = 2'd2;
	localparam tally_t TALLY_FULL  = 2'd3;

endpackage

// ===== hw/rtl/point_in_polygon_even_odd.sv =====
// Top level of the streaming even-odd point-in-polygon test.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------------
//   input   | in_valid, in_stall | vertex_x, vertex_y, point_x, point_y,
//           |                    | ends_polygon, ends_set
//   output  | out_valid,         | polygon_inside, set_inside, set_done
//           | out_stall          |
//
// The block takes one vertex per cycle while in_stall is low.
// The edge products are formed between the input register and the product register, and the
// compare and parity update between the product register and the result register.
// Reset clears the valid bits, the vertex tally and the parities and opens a new set.
// A stalled result holds the pipeline behind it only when that stage also carries a result.
`timescale 1ns / 1ps

module point_in_polygon_even_odd #(
	parameter int COORD_BITS = pip_pkg::PIP_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_y,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         ends_polygon,
	input  logic                         ends_set,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         polygon_inside,
	output logic                         set_inside,
	output logic                         set_done
);

	import pip_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	typedef struct packed {
		logic                 span;
		logic signed [PW-1:0] lhs;
		logic signed [PW-1:0] rhs;
	} edge_terms_t;

	// The point is above the edge when (py - yl) * (xh - xl) > (yh - yl) * (px - xl).
	function automatic edge_terms_t edge_terms(
		input logic signed [COORD_BITS-1:0] x0,
		input logic signed [COORD_BITS-1:0] y0,
		input logic signed [COORD_BITS-1:0] x1,
		input logic signed [COORD_BITS-1:0] y1,
		input logic signed [COORD_BITS-1:0] px,
		input logic signed [COORD_BITS-1:0] py
	);
		logic                         fwd;
		logic                         rev;
		logic signed [COORD_BITS-1:0] xl;
		logic signed [COORD_BITS-1:0] yl;
		logic signed [COORD_BITS-1:0] xh;
		logic signed [COORD_BITS-1:0] yh;
		logic signed [DW-1:0]         dpy;
		logic signed [DW-1:0]         dx;
		logic signed [DW-1:0]         dy;
		logic signed [DW-1:0]         dpx;
		edge_terms_t                  r;
		fwd = (x0 < px) && (px <= x1);
		rev = (x1 < px) && (px <= x0);
		xl = fwd ? x0 : x1;
		yl = fwd ? y0 : y1;
		xh = fwd ? x1 : x0;
		yh = fwd ? y1 : y0;
		dpy = $signed({py[COORD_BITS-1], py}) - $signed({yl[COORD_BITS-1], yl});
		dx  = $signed({xh[COORD_BITS-1], xh}) - $signed({xl[COORD_BITS-1], xl});
		dy  = $signed({yh[COORD_BITS-1], yh}) - $signed({yl[COORD_BITS-1], yl});
		dpx = $signed({px[COORD_BITS-1], px}) - $signed({xl[COORD_BITS-1], xl});
		r.span = fwd || rev;
		r.lhs  = PW'(dpy) * PW'(dx);
		r.rhs  = PW'(dy) * PW'(dpx);
		return r;
	endfunction

	// Input register.
	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] vx_s1;
	logic signed [COORD_BITS-1:0] vy_s1;
	logic signed [COORD_BITS-1:0] px_s1;
	logic signed [COORD_BITS-1:0] py_s1;
	logic                         poly_end_s1;
	logic                         set_end_s1;

	// Per-polygon and per-set state, advanced as a vertex leaves the input register.
	logic signed [COORD_BITS-1:0] first_vx_q;
	logic signed [COORD_BITS-1:0] first_vy_q;
	logic signed [COORD_BITS-1:0] prev_vx_q;
	logic signed [COORD_BITS-1:0] prev_vy_q;
	logic signed [COORD_BITS-1:0] held_px_q;
	logic signed [COORD_BITS-1:0] held_py_q;
	tally_t                       tally_q;
	logic                         at_set_start_q;

	// Product register.
	logic                 valid_s2;
	logic                 span_a_s2;
	logic signed [PW-1:0] lhs_a_s2;
	logic signed [PW-1:0] rhs_a_s2;
	logic                 span_b_s2;
	logic signed [PW-1:0] lhs_b_s2;
	logic signed [PW-1:0] rhs_b_s2;
	logic                 poly_end_s2;
	logic                 set_end_s2;
	logic                 fresh_poly_s2;
	logic                 fresh_set_s2;
	logic                 full_s2;

	logic crossing_parity_q;
	logic containing_parity_q;

	logic out_ready;
	logic s2_fire;
	logic s2_open;
	logic s1_fire;
	logic in_fire;

	logic signed [COORD_BITS-1:0] cur_px;
	logic signed [COORD_BITS-1:0] cur_py;
	logic signed [COORD_BITS-1:0] cur_first_x;
	logic signed [COORD_BITS-1:0] cur_first_y;
	edge_terms_t                  edge_a;
	edge_terms_t                  edge_b;

	logic cross_a;
	logic cross_b;
	logic crossing_parity_new;
	logic poly_inside;
	logic containing_base;
	logic containing_new;

	assign out_ready = !out_valid || !out_stall;
	assign s2_fire   = valid_s2 && (!poly_end_s2 || out_ready);
	assign s2_open   = !valid_s2 || s2_fire;
	assign s1_fire   = valid_s1 && s2_open;
	assign in_stall  = valid_s1 && !s2_open;
	assign in_fire   = in_valid && !in_stall;

	always_comb begin
		cur_px      = at_set_start_q ? px_s1 : held_px_q;
		cur_py      = at_set_start_q ? py_s1 : held_py_q;
		cur_first_x = (tally_q == TALLY_EMPTY) ? vx_s1 : first_vx_q;
		cur_first_y = (tally_q == TALLY_EMPTY) ? vy_s1 : first_vy_q;
		edge_a = edge_terms(prev_vx_q, prev_vy_q, vx_s1, vy_s1, cur_px, cur_py);
		edge_b = edge_terms(vx_s1, vy_s1, cur_first_x, cur_first_y, cur_px, cur_py);
	end

	always_comb begin
		cross_a             = span_a_s2 && (lhs_a_s2 > rhs_a_s2);
		cross_b             = span_b_s2 && (lhs_b_s2 > rhs_b_s2);
		crossing_parity_new = (fresh_poly_s2 ? 1'b0 : crossing_parity_q) ^ cross_a ^ cross_b;
		poly_inside         = full_s2 && crossing_parity_new;
		containing_base     = fresh_set_s2 ? 1'b0 : containing_parity_q;
		containing_new      = containing_base ^ poly_inside;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !s1_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			vx_s1       <= vertex_x;
			vy_s1       <= vertex_y;
			px_s1       <= point_x;
			py_s1       <= point_y;
			poly_end_s1 <= ends_polygon || ends_set;
			set_end_s1  <= ends_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q        <= TALLY_EMPTY;
			at_set_start_q <= 1'b1;
		end else if (s1_fire) begin
			if (poly_end_s1) begin
				tally_q <= TALLY_EMPTY;
			end else if (tally_q != TALLY_FULL) begin
				tally_q <= tally_q + 2'd1;
			end
			at_set_start_q <= set_end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			if (at_set_start_q) begin
				held_px_q <= px_s1;
				held_py_q <= py_s1;
			end
			if (tally_q == TALLY_EMPTY) begin
				first_vx_q <= vx_s1;
				first_vy_q <= vy_s1;
			end
			prev_vx_q <= vx_s1;
			prev_vy_q <= vy_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_open) begin
			valid_s2 <= s1_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			span_a_s2     <= edge_a.span && (tally_q != TALLY_EMPTY);
			lhs_a_s2      <= edge_a.lhs;
			rhs_a_s2      <= edge_a.rhs;
			span_b_s2     <= edge_b.span && poly_end_s1;
			lhs_b_s2      <= edge_b.lhs;
			rhs_b_s2      <= edge_b.rhs;
			poly_end_s2   <= poly_end_s1;
			set_end_s2    <= set_end_s1;
			fresh_poly_s2 <= (tally_q == TALLY_EMPTY);
			fresh_set_s2  <= at_set_start_q;
			full_s2       <= (tally_q >= TALLY_PAIR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crossing_parity_q   <= 1'b0;
			containing_parity_q <= 1'b0;
		end else if (s2_fire) begin
			crossing_parity_q <= poly_end_s2 ? 1'b0 : crossing_parity_new;
			if (set_end_s2) begin
				containing_parity_q <= 1'b0;
			end else if (poly_end_s2) begin
				containing_parity_q <= containing_new;
			end else begin
				containing_parity_q <= containing_base;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= s2_fire && poly_end_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && s2_fire && poly_end_s2) begin
			polygon_inside <= poly_inside;
			set_inside     <= containing_new;
			set_done       <= set_end_s2;
		end
	end

`ifndef SYNTH
	a_stall_needs_held_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_polygon_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && poly_end_s2 && out_ready) |=> out_valid)
		else $error("polygon end left the pipeline without a result");

	a_set_end_reopens_set: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && set_end_s1) |=> (at_set_start_q && (tally_q == TALLY_EMPTY)))
		else $error("set end did not reopen a set");
`endif

endmodule

// ===== verif/point_in_polygon_even_odd_test.sv =====
// Self-checking testbench for the streaming even-odd point-in-polygon block.
`timescale 1ns / 1ps

module point_in_polygon_even_odd_test;

	import pip_pkg::*;

	localparam int COORD_BITS = PIP_COORD_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic polygon_inside;
		logic set_inside;
		logic set_done;
	} verdict_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam int RESET_CYCLES = 12;
	localparam int DRAIN_CYCLES = 16;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SET_STREAM_ITEMS = 680;
	localparam int NOISE_ITEMS = 200;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	coord_t vertex_x;
	coord_t vertex_y;
	coord_t point_x;
	coord_t point_y;
	logic ends_polygon;
	logic ends_set;
	logic out_valid;
	logic out_stall;
	logic polygon_inside;
	logic set_inside;
	logic set_done;

	verdict_t pending_verdicts[$];
	int unsigned mismatch_count = 0;
	int unsigned vertices_sent = 0;
	int unsigned quiet_cycles = 0;
	int unsigned sender_pause_max = 0;
	int unsigned receiver_pause_max = 0;

	coord_t first_x = '0;
	coord_t first_y = '0;
	coord_t last_x = '0;
	coord_t last_y = '0;
	coord_t query_x = '0;
	coord_t query_y = '0;
	tally_t corner_count = TALLY_EMPTY;
	logic crossing_odd = 1'b0;
	logic containing_odd = 1'b0;
	logic opening_set = 1'b1;

	point_in_polygon_even_odd dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.point_x(point_x),
		.point_y(point_y),
		.ends_polygon(ends_polygon),
		.ends_set(ends_set),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.polygon_inside(polygon_inside),
		.set_inside(set_inside),
		.set_done(set_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic crosses_edge(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		longint lx, ly, hx, hy, qx, qy;
		qx = query_x;
		qy = query_y;
		if (longint'(ax) < qx && qx <= longint'(bx)) begin
			lx = ax;
			ly = ay;
			hx = bx;
			hy = by;
		end else if (longint'(bx) < qx && qx <= longint'(ax)) begin
			lx = bx;
			ly = by;
			hx = ax;
			hy = ay;
		end else begin
			return 1'b0;
		end
		return ((qy - ly) * (hx - lx)) > ((hy - ly) * (qx - lx));
	endfunction

	function automatic void predict_verdict(coord_t vx, coord_t vy, coord_t px, coord_t py,
			logic poly_flag, logic set_flag);
		verdict_t verdict;
		if (opening_set) begin
			query_x = px;
			query_y = py;
			containing_odd = 1'b0;
			opening_set = 1'b0;
		end
		if (corner_count == TALLY_EMPTY) begin
			first_x = vx;
			first_y = vy;
			crossing_odd = 1'b0;
		end else begin
			crossing_odd ^= crosses_edge(last_x, last_y, vx, vy);
		end
		last_x = vx;
		last_y = vy;
		if (corner_count != TALLY_FULL)
			corner_count = corner_count + 2'd1;
		if (poly_flag || set_flag) begin
			crossing_odd ^= crosses_edge(vx, vy, first_x, first_y);
			verdict.polygon_inside = (corner_count == TALLY_FULL) && crossing_odd;
			containing_odd ^= verdict.polygon_inside;
			verdict.set_inside = containing_odd;
			verdict.set_done = set_flag;
			pending_verdicts.insert(pending_verdicts.size(), verdict);
			corner_count = TALLY_EMPTY;
			crossing_odd = 1'b0;
			if (set_flag) begin
				opening_set = 1'b1;
				containing_odd = 1'b0;
			end
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic check_field(input string field, input logic got, input logic want);
		if (got !== want)
			report_mismatch($sformatf("%s is %b, expected %b", field, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			predict_verdict(vertex_x, vertex_y, point_x, point_y, ends_polygon, ends_set);
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
			end else begin
				want = pending_verdicts.pop_front();
				check_field("polygon_inside", polygon_inside, want.polygon_inside);
				check_field("set_inside", set_inside, want.set_inside);
				check_field("set_done", set_done, want.set_done);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int unsigned hold;
		out_stall = 1'b0;
		forever begin
			hold = $urandom_range(0, receiver_pause_max);
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send_vertex(input coord_t vx, input coord_t vy, input coord_t px,
			input coord_t py, input logic poly_flag, input logic set_flag);
		int unsigned gap;
		gap = $urandom_range(0, sender_pause_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= vx;
		vertex_y <= vy;
		point_x <= px;
		point_y <= py;
		ends_polygon <= poly_flag;
		ends_set <= set_flag;
		do @(posedge clk); while (in_stall);
		vertices_sent++;
	endtask

	function automatic int unsigned pick_pause();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 4;
			default: return 16;
		endcase
	endfunction

	function automatic coord_t random_coord();
		return coord_t'($urandom());
	endfunction

	function automatic coord_t coord_near(coord_t centre, int unsigned reach);
		longint pick;
		if ($urandom_range(0, 7) == 0)
			return centre;
		pick = longint'(centre) + longint'($urandom_range(0, 2 * reach)) - longint'(reach);
		if (pick > longint'(COORD_MAX))
			pick = COORD_MAX;
		if (pick < longint'(COORD_MIN))
			pick = COORD_MIN;
		return coord_t'(pick);
	endfunction

	task automatic test_basic_containment();
		send_vertex(-256, -256, 0, 0, 1'b0, 1'b0);
		send_vertex(256, -256, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
		send_vertex(256, 256, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
		send_vertex(-256, 256, COORD_MAX, COORD_MIN, 1'b1, 1'b0);
		send_vertex(-4096, -4096, COORD_MIN, COORD_MAX, 1'b0, 1'b0);
		send_vertex(4096, -4096, 0, 0, 1'b0, 1'b0);
		send_vertex(4096, 4096, 0, 0, 1'b0, 1'b0);
		send_vertex(-4096, 4096, 0, 0, 1'b1, 1'b1);
	endtask

	task automatic test_small_polygons();
		send_vertex(COORD_MAX, COORD_MAX, 0, 0, 1'b1, 1'b0);
		send_vertex(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 1'b1);
	endtask

	task automatic test_boundary_edges();
		send_vertex(0, 0, 0, 256, 1'b0, 1'b0);
		send_vertex(0, 512, 0, 0, 1'b0, 1'b0);
		send_vertex(512, 0, 0, 0, 1'b1, 1'b0);
		send_vertex(-256, 256, 0, 0, 1'b0, 1'b0);
		send_vertex(256, 256, 0, 0, 1'b0, 1'b0);
		send_vertex(0, -512, 0, 0, 1'b1, 1'b1);
	endtask

	task automatic test_extreme_coordinates();
		send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, 0, 0, 1'b0, 1'b0);
		send_vertex(COORD_MAX, COORD_MIN, 0, 0, 1'b1, 1'b1);
		send_vertex(COORD_MIN, COORD_MIN, COORD_MAX, 0, 1'b0, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, 0, 0, 1'b0, 1'b0);
		send_vertex(COORD_MIN, COORD_MAX, 0, 0, 1'b1, 1'b1);
	endtask

	task automatic test_random_sets();
		coord_t qx, qy;
		int unsigned reach, polygons, corners;
		logic last_polygon, last_corner;
		while (vertices_sent < SET_STREAM_ITEMS) begin
			sender_pause_max = pick_pause();
			receiver_pause_max = pick_pause();
			qx = random_coord();
			qy = random_coord();
			case ($urandom_range(0, 3))
				0: reach = 16;
				1: reach = 1024;
				2: reach = 65536;
				default: reach = 1 << (COORD_BITS - 1);
			endcase
			polygons = $urandom_range(1, 4);
			for (int p = 0; p < polygons; p++) begin
				corners = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
				for (int c = 0; c < corners; c++) begin
					last_polygon = (p == polygons - 1);
					last_corner = (c == corners - 1);
					send_vertex(coord_near(qx, reach), coord_near(qy, reach),
						(p == 0 && c == 0) ? qx : random_coord(),
						(p == 0 && c == 0) ? qy : random_coord(),
						last_corner && (!last_polygon || $urandom_range(0, 1) == 1),
						last_corner && last_polygon);
				end
			end
		end
	endtask

	task automatic test_random_noise();
		for (int n = 0; n < NOISE_ITEMS; n++) begin
			if (n % 50 == 0) begin
				sender_pause_max = pick_pause();
				receiver_pause_max = pick_pause();
			end
			send_vertex(random_coord(), random_coord(), random_coord(), random_coord(),
				$urandom_range(0, 3) == 0, (n == NOISE_ITEMS - 1) || $urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		vertex_x = '0;
		vertex_y = '0;
		point_x = '0;
		point_y = '0;
		ends_polygon = 1'b0;
		ends_set = 1'b0;
		sender_pause_max = 3;
		receiver_pause_max = 3;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_basic_containment();
		test_small_polygons();
		test_boundary_edges();
		test_extreme_coordinates();
		test_random_sets();
		test_random_noise();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
